>>> hw/rtl/bfp_pkg.sv
// Shared types and constants for the bit field packer.
// Holds the command codes, field widths and the packer state and result structs.
// No dependencies.
package bfp_pkg;

  localparam int unsigned WordBits        = 32;
  localparam int unsigned ScratchBits     = 64;
  localparam int unsigned ByteBits        = 8;
  localparam int unsigned MaxWordsDefault = 4096;
  localparam int unsigned CapWidth        = 13;
  localparam int unsigned AddrWidth       = 12;
  localparam int unsigned TotalWidth      = 18;
  localparam int unsigned FieldWidthBits  = 6;
  localparam int unsigned PosWidth        = 5;
  localparam int unsigned InDataWidth     = 40;
  localparam int unsigned OutDataWidth    = 64;

  localparam logic [CapWidth-1:0] CapReset = 13'd4096;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_ALIGN   = 2'd1,
    CMD_FLUSH   = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [ScratchBits-1:0] scratch;
    logic [PosWidth-1:0]    bit_pos;
    logic [CapWidth-1:0]    word_count;
    logic [TotalWidth-1:0]  bits_total;
    logic                   ovf;
  } pack_state_t;

  typedef struct packed {
    logic                  word_valid;
    logic [WordBits-1:0]   word;
    logic [AddrWidth-1:0]  addr;
    logic                  ovf;
    logic [TotalWidth-1:0] bits_packed;
  } pack_result_t;

endpackage

>>> hw/rtl/bfp_step.sv
// Combinational next-state and result logic for one packer request.
// Depends on bfp_pkg for the command codes and the state and result structs.
module bfp_step #(
  parameter int unsigned MAX_WORDS = bfp_pkg::MaxWordsDefault
) (
  input  bfp_pkg::pack_state_t                 state_i,
  input  bfp_pkg::cmd_t                        cmd_i,
  input  logic [bfp_pkg::WordBits-1:0]         value_i,
  input  logic [bfp_pkg::FieldWidthBits-1:0]   width_i,
  input  logic [bfp_pkg::CapWidth-1:0]         cap_cfg_i,
  output bfp_pkg::pack_state_t                 state_o,
  output bfp_pkg::pack_result_t                result_o
);

  localparam logic [16:0] MaxWordsL = 17'(MAX_WORDS);

  logic [bfp_pkg::CapWidth-1:0]       cap;
  logic [bfp_pkg::TotalWidth-1:0]     cap_bits;
  logic                               do_pack;
  logic [bfp_pkg::FieldWidthBits-1:0] pack_bits;
  logic [bfp_pkg::WordBits-1:0]       pack_val;
  logic [2:0]                         rem;
  logic [bfp_pkg::TotalWidth:0]       total_sum;
  logic                               fits;
  logic [bfp_pkg::ScratchBits-1:0]    mask64;
  logic [bfp_pkg::WordBits-1:0]       masked;
  logic [bfp_pkg::FieldWidthBits-1:0] shamt;
  logic [bfp_pkg::ScratchBits-1:0]    ored;
  logic [bfp_pkg::FieldWidthBits-1:0] pos_sum;
  logic                               wc_ok;

  always_comb begin
    cap      = ({4'b0, cap_cfg_i} > MaxWordsL) ? bfp_pkg::CapWidth'(MaxWordsL) : cap_cfg_i;
    cap_bits = {cap, 5'b0};
    wc_ok    = state_i.word_count < cap;
    rem      = state_i.bits_total[2:0];

    do_pack   = 1'b0;
    pack_bits = '0;
    pack_val  = '0;
    unique case (cmd_i)
      bfp_pkg::CMD_WRITE: begin
        pack_bits = (width_i > 6'd32) ? 6'd32 : width_i;
        do_pack   = (width_i != '0);
        pack_val  = value_i;
      end
      bfp_pkg::CMD_ALIGN: begin
        do_pack   = (rem != 3'd0);
        pack_bits = 6'(4'd8 - {1'b0, rem});
      end
      default: begin
      end
    endcase

    total_sum = {1'b0, state_i.bits_total} + (bfp_pkg::TotalWidth + 1)'(pack_bits);
    fits      = total_sum <= {1'b0, cap_bits};
    mask64    = (64'd1 << pack_bits) - 64'd1;
    masked    = pack_val & mask64[bfp_pkg::WordBits-1:0];
    // The field's highest bit lands just below the bits already gathered.
    shamt     = 6'(7'd64 - {2'b0, state_i.bit_pos} - {1'b0, pack_bits});
    ored      = state_i.scratch | ({32'b0, masked} << shamt);
    pos_sum   = {1'b0, state_i.bit_pos} + pack_bits;

    state_o  = state_i;
    result_o = '0;

    unique case (cmd_i)
      bfp_pkg::CMD_WRITE, bfp_pkg::CMD_ALIGN: begin
        if (do_pack) begin
          if (!fits) begin
            state_o.ovf = 1'b1;
          end else begin
            state_o.scratch    = ored;
            state_o.bit_pos    = pos_sum[bfp_pkg::PosWidth-1:0];
            state_o.bits_total = total_sum[bfp_pkg::TotalWidth-1:0];
            if (pos_sum[bfp_pkg::PosWidth]) begin
              // A full word is ready; it is dropped when no buffer slot is left.
              state_o.scratch = {ored[bfp_pkg::WordBits-1:0], 32'b0};
              if (wc_ok) begin
                result_o.word_valid = 1'b1;
                result_o.word       = ored[bfp_pkg::ScratchBits-1:bfp_pkg::WordBits];
                result_o.addr       = state_i.word_count[bfp_pkg::AddrWidth-1:0];
                state_o.word_count  = state_i.word_count + 13'd1;
              end else begin
                state_o.ovf = 1'b1;
              end
            end
          end
        end
      end
      bfp_pkg::CMD_FLUSH: begin
        // The partial word goes out but the bit position and scratch stay put.
        if (state_i.bit_pos != '0) begin
          if (!wc_ok) begin
            state_o.ovf = 1'b1;
          end else begin
            result_o.word_valid = 1'b1;
            result_o.word       = state_i.scratch[bfp_pkg::ScratchBits-1:bfp_pkg::WordBits];
            result_o.addr       = state_i.word_count[bfp_pkg::AddrWidth-1:0];
            state_o.word_count  = state_i.word_count + 13'd1;
          end
        end
      end
      bfp_pkg::CMD_RESTART: begin
        state_o = '0;
      end
      default: begin
      end
    endcase

    result_o.ovf         = state_o.ovf;
    result_o.bits_packed = state_o.bits_total;
  end

endmodule

>>> hw/rtl/bit_field_packer_unit.sv
// Bit field packer: one request in, one result out, with an input and a result register.
// An accepted request passes through the input register and then the result register.
// Throughput is one request per cycle while the output is not stalled; the state update in bfp_step sets the pace.
// A stalled output holds one result while one more request waits in the input register.
// Synchronous active-low reset empties both registers, clears the packer state and
// sets the capacity register to 4096 words.
module bit_field_packer_unit #(
  parameter int unsigned MAX_WORDS = bfp_pkg::MaxWordsDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // field_value [31:0], field_width [37:32], zero fill [39:38]
  input  logic [bfp_pkg::InDataWidth-1:0]     in_tdata,
  // cmd [1:0]
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_word [31:0], word_address [43:32], overflow [44], bits_packed [62:45], zero [63]
  output logic [bfp_pkg::OutDataWidth-1:0]    out_tdata,
  // word_valid [0]
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic [bfp_pkg::CapWidth-1:0]        cfg_wdata
);

  logic                                 s1_valid_r, s1_valid_nxt;
  bfp_pkg::cmd_t                        s1_cmd_r;
  logic [bfp_pkg::WordBits-1:0]         s1_value_r;
  logic [bfp_pkg::FieldWidthBits-1:0]   s1_width_r;
  logic                                 out_valid_r, out_valid_nxt;
  bfp_pkg::pack_result_t                out_res_r;
  bfp_pkg::pack_state_t                 state_r, state_nxt;
  bfp_pkg::pack_result_t                step_res;
  logic [bfp_pkg::CapWidth-1:0]         cap_r;
  logic                                 in_accept;
  logic                                 advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  bfp_step #(
    .MAX_WORDS (MAX_WORDS)
  ) u_step (
    .state_i   (state_r),
    .cmd_i     (s1_cmd_r),
    .value_i   (s1_value_r),
    .width_i   (s1_width_r),
    .cap_cfg_i (cap_r),
    .state_o   (state_nxt),
    .result_o  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      cap_r       <= bfp_pkg::CapReset;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r   <= bfp_pkg::cmd_t'(in_tuser);
      s1_value_r <= in_tdata[31:0];
      s1_width_r <= in_tdata[37:32];
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.word_valid;
  assign out_tdata  = {1'b0, out_res_r.bits_packed, out_res_r.ovf, out_res_r.addr,
                       out_res_r.word};

endmodule

>>> sim/packed_word_board_pkg.sv
// Scoreboard for the bit field packer: predicts each result from the accepted requests
// and checks the results that leave the block. Depends on bfp_pkg for the command codes
// and the result struct.
package packed_word_board_pkg;
  import bfp_pkg::*;

  class packed_word_board;
    int unsigned max_words;
    logic [CapWidth-1:0] capacity;
    logic [ScratchBits-1:0] scratch;
    int unsigned bit_pos;
    int unsigned word_count;
    int unsigned bits_total;
    bit ovf;
    pack_result_t next_word;
    pack_result_t pending_words[$];
    int unsigned error_count;

    function new(int unsigned words_limit);
      max_words = words_limit;
      capacity = CapReset;
      error_count = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      scratch = '0;
      bit_pos = 0;
      word_count = 0;
      bits_total = 0;
      ovf = 1'b0;
    endfunction

    function void set_capacity(logic [CapWidth-1:0] words);
      capacity = words;
    endfunction

    function int unsigned usable_words();
      return (capacity > max_words) ? max_words : capacity;
    endfunction

    function int unsigned pending_count();
      return pending_words.size();
    endfunction

    // Appends nbits (1 to 32) of value, most significant bit first.
    function void append_bits(logic [WordBits-1:0] value, int unsigned nbits);
      int unsigned cap;
      logic [ScratchBits-1:0] masked;
      cap = usable_words();
      if (bits_total + nbits > cap * WordBits) begin
        ovf = 1'b1;
        return;
      end
      masked = {32'd0, value} & ((64'd1 << nbits) - 64'd1);
      scratch |= masked << (ScratchBits - bit_pos - nbits);
      bit_pos += nbits;
      if (bit_pos >= WordBits) begin
        // A completed word beyond the capacity is lost, but its bits still count.
        if (word_count < cap) begin
          next_word.word_valid = 1'b1;
          next_word.word = scratch[63:32];
          next_word.addr = word_count[AddrWidth-1:0];
          word_count++;
        end else begin
          ovf = 1'b1;
        end
        scratch = scratch << WordBits;
        bit_pos -= WordBits;
      end
      bits_total += nbits;
    endfunction

    function void note_request(cmd_t cmd, logic [WordBits-1:0] value,
                               logic [FieldWidthBits-1:0] width);
      int unsigned nbits;
      next_word = '0;
      case (cmd)
        CMD_WRITE: begin
          nbits = (width > WordBits) ? WordBits : width;
          if (nbits != 0) append_bits(value, nbits);
        end
        CMD_ALIGN: begin
          if (bits_total % ByteBits != 0) append_bits('0, ByteBits - bits_total % ByteBits);
        end
        CMD_FLUSH: begin
          // The partial word goes out but the bit position and scratch stay as they are.
          if (bit_pos != 0) begin
            if (word_count >= usable_words()) begin
              ovf = 1'b1;
            end else begin
              next_word.word_valid = 1'b1;
              next_word.word = scratch[63:32];
              next_word.addr = word_count[AddrWidth-1:0];
              word_count++;
            end
          end
        end
        default: begin
          clear_packet();
        end
      endcase
      next_word.ovf = ovf;
      next_word.bits_packed = bits_total[TotalWidth-1:0];
      pending_words.push_back(next_word);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        error_count++;
      end
    endfunction

    function void check_word(logic word_valid, logic [OutDataWidth-1:0] tdata);
      pack_result_t want;
      if (pending_words.size() == 0) begin
        $error("result arrived with no request outstanding: tdata 0x%0h", tdata);
        error_count++;
        return;
      end
      want = pending_words.pop_front();
      compare_field("word_valid", want.word_valid, word_valid);
      compare_field("out_word", want.word, tdata[31:0]);
      compare_field("word_address", want.addr, tdata[43:32]);
      compare_field("overflow", want.ovf, tdata[44]);
      compare_field("bits_packed", want.bits_packed, tdata[62:45]);
      compare_field("zero fill", 1'b0, tdata[63]);
    endfunction
  endclass

endpackage

>>> sim/testbench.sv
// Top level testbench for bit_field_packer_unit: directed and random packets under
// random sender bursts and receiver stalls. Depends on bfp_pkg and packed_word_board_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bfp_pkg::*;
  import packed_word_board_pkg::*;

  localparam int unsigned MaxWords = MaxWordsDefault;
  localparam int unsigned PhaseItems = 85;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [InDataWidth-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OutDataWidth-1:0] out_tdata;
  logic out_tuser;
  logic cfg_we;
  logic [CapWidth-1:0] cfg_wdata;

  packed_word_board board = new(MaxWords);
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  bit_field_packer_unit #(.MAX_WORDS(MaxWords)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("bit_field_packer_unit: mismatch");
    $finish;
  end

  // Results are checked before the request of the same edge is noted; a result can
  // only belong to an earlier request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.set_capacity(cfg_wdata);
      if (out_tvalid && out_tready) board.check_word(out_tuser, out_tdata);
      if (in_tvalid && in_tready) begin
        board.note_request(cmd_t'(in_tuser), in_tdata[31:0], in_tdata[37:32]);
      end
    end
  end

  // The receiver switches between stall patterns of random length.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    out_tready = 1'b0;
    @(posedge rst_n);
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(cmd_t cmd, logic [31:0] value, logic [5:0] width);
    in_tuser <= cmd;
    in_tdata <= {2'b00, width, value};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(logic [CapWidth-1:0] words);
    drain_results();
    cfg_wdata <= words;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [5:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 6'd0;
      1: return 6'($urandom_range(33, 63));
      2: return 6'd32;
      3: return 6'd1;
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Mostly whole packets: restart, fields with the odd align or flush, then align and flush.
  task automatic run_packets(int unsigned quota);
    int unsigned start;
    int unsigned fields;
    int unsigned r;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 99) < 85) begin
        send_request(CMD_RESTART, pick_value(), pick_width());
        pace_sender();
        fields = $urandom_range(1, 24);
        repeat (fields) begin
          r = $urandom_range(0, 99);
          if (r < 8) send_request(CMD_ALIGN, pick_value(), pick_width());
          else if (r < 14) send_request(CMD_FLUSH, pick_value(), pick_width());
          else send_request(CMD_WRITE, pick_value(), pick_width());
          pace_sender();
        end
        send_request(CMD_ALIGN, pick_value(), pick_width());
        pace_sender();
        send_request(CMD_FLUSH, pick_value(), pick_width());
        pace_sender();
        if ($urandom_range(0, 29) == 0) drain_results();
      end else begin
        send_request(cmd_t'($urandom_range(0, 3)), $urandom, 6'($urandom_range(0, 63)));
        pace_sender();
      end
    end
  endtask

  initial begin
    int unsigned cap_plan[10];
    cap_plan = '{1, 2, 3, 5, 8191, 0, 4096, 8, 13, 40};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_WRITE;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full-width, single-bit, zero-width and oversized fields at the default capacity.
    send_request(CMD_WRITE, 32'hFFFF_FFFF, 6'd32);
    send_request(CMD_WRITE, 32'h0000_0001, 6'd1);
    send_request(CMD_WRITE, 32'hDEAD_BEEF, 6'd0);
    send_request(CMD_WRITE, 32'hA5A5_A5A5, 6'd63);
    send_request(CMD_ALIGN, 32'd0, 6'd0);
    send_request(CMD_ALIGN, 32'd0, 6'd0);
    send_request(CMD_WRITE, 32'hFFFF_FABC, 6'd12);
    send_request(CMD_FLUSH, 32'd0, 6'd0);
    send_request(CMD_FLUSH, 32'd0, 6'd0);
    send_request(CMD_RESTART, 32'd0, 6'd0);
    send_request(CMD_FLUSH, 32'd0, 6'd0);
    send_request(CMD_WRITE, 32'd0, 6'd32);

    // One word of room: a write past it overflows, and so does a flush with no word left.
    write_capacity(13'd1);
    send_request(CMD_RESTART, 32'd0, 6'd0);
    send_request(CMD_WRITE, 32'h1234_5678, 6'd32);
    send_request(CMD_WRITE, 32'h0000_0001, 6'd1);
    send_request(CMD_RESTART, 32'd0, 6'd0);
    send_request(CMD_WRITE, 32'h0000_0009, 6'd4);
    send_request(CMD_FLUSH, 32'd0, 6'd0);
    send_request(CMD_FLUSH, 32'd0, 6'd0);

    // A flush uses up a word, so a later completed word falls beyond the capacity.
    write_capacity(13'd2);
    send_request(CMD_RESTART, 32'd0, 6'd0);
    send_request(CMD_WRITE, 32'h0000_000F, 6'd4);
    send_request(CMD_FLUSH, 32'd0, 6'd0);
    send_request(CMD_WRITE, 32'h0ABC_DEF1, 6'd28);
    send_request(CMD_WRITE, 32'hCAFE_F00D, 6'd32);

    write_capacity(13'd0);
    send_request(CMD_WRITE, 32'h0000_001F, 6'd5);
    send_request(CMD_RESTART, 32'd0, 6'd0);

    for (int i = 0; i < 10; i++) begin
      write_capacity((i == 9) ? CapWidth'($urandom_range(1, 64)) : CapWidth'(cap_plan[i]));
      run_packets(PhaseItems);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (board.error_count == 0) begin
      $display("bit_field_packer_unit: match");
    end else begin
      $display("bit_field_packer_unit: mismatch");
    end
    $finish;
  end

endmodule
